[rtl/ppp_pkg.sv]
// Package for the perspective point projection core: types and constants.
package ppp_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_IDX_W       = 3;
   localparam int DIM_W           = 15;
   localparam int ENT_W           = 32;
   // Clip values stay well inside this width (three clamped products plus a 32-bit entry).
   localparam int CLIP_W          = 64;
   localparam int NDC_LIM_LOG2    = 47;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_X   = 3'd0,
      REG_ROW_Y   = 3'd1,
      REG_ROW_Z   = 3'd2,
      REG_ROW_T   = 3'd3,
      REG_W_UPPER = 3'd4,
      REG_W_LOWER = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } csr_idx_type;

   localparam logic [CSR_DATA_W-1:0] RST_ROW_X   = 64'd65536;
   localparam logic [CSR_DATA_W-1:0] RST_ROW_Y   = 64'd281474976710656;
   localparam logic [CSR_DATA_W-1:0] RST_ROW_Z   = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RST_ROW_T   = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RST_W_UPPER = 64'd0;
   localparam logic [CSR_DATA_W-1:0] RST_W_LOWER = 64'd281474976710656;
   localparam logic [DIM_W-1:0]      RST_WIDTH   = 15'd1920;
   localparam logic [DIM_W-1:0]      RST_HEIGHT  = 15'd1080;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] world_x;
      logic signed [COORD_WIDTH_DEF-1:0] world_y;
      logic signed [COORD_WIDTH_DEF-1:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] screen_x;
      logic signed [COORD_WIDTH_DEF-1:0] screen_y;
      logic                              visible;
   } rsp_type;

   // Per-stage control carried alongside the division chain.
   typedef struct packed {
      logic valid;
      logic vis;
      logic neg_x;
      logic neg_y;
      logic sat_x;
      logic sat_y;
   } div_ctl_type;

endpackage

[rtl/ppp_mac.sv]
// Clip stage: three fixed-point products per output column, registered, then summed.
module ppp_mac #(
   parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [COORD_WIDTH-1:0]         in_x,
   input  logic signed [COORD_WIDTH-1:0]         in_y,
   input  logic signed [COORD_WIDTH-1:0]         in_z,
   input  logic signed [ppp_pkg::ENT_W-1:0]      m_x,
   input  logic signed [ppp_pkg::ENT_W-1:0]      m_y,
   input  logic signed [ppp_pkg::ENT_W-1:0]      m_z,
   input  logic signed [ppp_pkg::ENT_W-1:0]      m_t,
   output logic                                  out_valid,
   output logic signed [ppp_pkg::CLIP_W-1:0]     out_clip
);
   localparam int PW = COORD_WIDTH + ppp_pkg::ENT_W;
   localparam int CW = ppp_pkg::CLIP_W;
   localparam logic [CW-1:0] LIM = CW'(1) << 60;

   logic signed [PW-1:0] p_ff [3];
   logic signed [ppp_pkg::ENT_W-1:0] t_ff;
   logic valid_ff;
   logic signed [CW-1:0] s_ff;
   logic valid2_ff;

   function automatic logic signed [CW-1:0] scale(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] sh;
      logic signed [CW-1:0] e;
      sh = p >>> FRAC_BITS;
      e = CW'(sh);
      if (e > $signed(LIM)) e = $signed(LIM);
      if (e < -$signed(LIM)) e = -$signed(LIM);
      return e;
   endfunction

   always_ff @(posedge clock) begin
      p_ff[0] <= PW'(in_x) * PW'(m_x);
      p_ff[1] <= PW'(in_y) * PW'(m_y);
      p_ff[2] <= PW'(in_z) * PW'(m_z);
      t_ff    <= m_t;
      s_ff    <= scale(p_ff[0]) + scale(p_ff[1]) + scale(p_ff[2]) + CW'(t_ff);
      if (reset) begin
         valid_ff  <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid_ff  <= in_valid;
         valid2_ff <= valid_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_clip  = s_ff;
endmodule

[rtl/ppp_div_cell.sv]
// One restoring-division cell: one quotient bit for x and y per cycle, shared divisor.
module ppp_div_cell #(
   parameter int QW = 48,
   parameter int DW = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ppp_pkg::div_ctl_type      in_ctl,
   input  logic [DW-1:0]             in_w,
   input  logic [DW:0]               in_rx,
   input  logic [DW:0]               in_ry,
   input  logic [QW-1:0]             in_qx,
   input  logic [QW-1:0]             in_qy,
   input  logic                      in_bx,
   input  logic                      in_by,
   output ppp_pkg::div_ctl_type      out_ctl,
   output logic [DW-1:0]             out_w,
   output logic [DW:0]               out_rx,
   output logic [DW:0]               out_ry,
   output logic [QW-1:0]             out_qx,
   output logic [QW-1:0]             out_qy
);
   logic [DW:0] tx, ty;
   logic        gx, gy;
   ppp_pkg::div_ctl_type ctl_ff;
   logic [DW-1:0] w_ff;
   logic [DW:0]   rx_ff, ry_ff;
   logic [QW-1:0] qx_ff, qy_ff;

   always_comb begin
      tx = {in_rx[DW-1:0], in_bx};
      ty = {in_ry[DW-1:0], in_by};
      gx = (tx >= {1'b0, in_w});
      gy = (ty >= {1'b0, in_w});
   end

   always_ff @(posedge clock) begin
      w_ff  <= in_w;
      rx_ff <= gx ? tx - {1'b0, in_w} : tx;
      ry_ff <= gy ? ty - {1'b0, in_w} : ty;
      qx_ff <= {in_qx[QW-2:0], gx};
      qy_ff <= {in_qy[QW-2:0], gy};
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_w   = w_ff;
   assign out_rx  = rx_ff;
   assign out_ry  = ry_ff;
   assign out_qx  = qx_ff;
   assign out_qy  = qy_ff;
endmodule

[rtl/perspective_point_projection_core.sv]
// Top level of the perspective point projection core.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------
//  input   | req_start, req_busy, req_data          | start && !busy
//  result  | rsp_strobe, rsp_data                   | strobe, one cycle, no stall
//  csr     | csr_write, csr_index, csr_data         | write enable, no wait
//
// One point accepted per cycle; each result passes through two multiply stages,
// FRAC_BITS + 63 divider cells (one quotient bit each, the integer part is computed bit by bit
// too) and two viewport stages.
// busy is always low; reset is synchronous and clears all valid bits.
module perspective_point_projection_core #(
   parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                req_busy,
   input  ppp_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output ppp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]      csr_data
);
   localparam int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF;
   localparam int EW = ppp_pkg::ENT_W;
   localparam int DW = ppp_pkg::CLIP_W;
   localparam int NL = ppp_pkg::NDC_LIM_LOG2;
   // Quotient bits: integer part of |c|/w up to the clamp plus FRAC_BITS fraction bits.
   localparam int QW = NL + 1;
   // Dividend bits fed in: |c| (DW-1 significant bits) then FRAC_BITS zeros.
   localparam int NB = DW - 1 + FRAC_BITS;
   localparam int NCELL = NB;
   localparam logic signed [DW-1:0] W_EPS = DW'((64'd1 << FRAC_BITS) / 10000);
   localparam logic [DW-1:0] NDC_LIM = DW'(1) << NL;

   logic [ppp_pkg::CSR_DATA_W-1:0] row_x_ff, row_y_ff, row_z_ff, row_t_ff, wu_ff, wl_ff;
   logic [ppp_pkg::DIM_W-1:0]      wd_ff, ht_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= ppp_pkg::RST_ROW_X;
         row_y_ff <= ppp_pkg::RST_ROW_Y;
         row_z_ff <= ppp_pkg::RST_ROW_Z;
         row_t_ff <= ppp_pkg::RST_ROW_T;
         wu_ff    <= ppp_pkg::RST_W_UPPER;
         wl_ff    <= ppp_pkg::RST_W_LOWER;
         wd_ff    <= ppp_pkg::RST_WIDTH;
         ht_ff    <= ppp_pkg::RST_HEIGHT;
      end else if (csr_write) begin
         case (ppp_pkg::csr_idx_type'(csr_index))
            ppp_pkg::REG_ROW_X:   row_x_ff <= csr_data;
            ppp_pkg::REG_ROW_Y:   row_y_ff <= csr_data;
            ppp_pkg::REG_ROW_Z:   row_z_ff <= csr_data;
            ppp_pkg::REG_ROW_T:   row_t_ff <= csr_data;
            ppp_pkg::REG_W_UPPER: wu_ff    <= csr_data;
            ppp_pkg::REG_W_LOWER: wl_ff    <= csr_data;
            ppp_pkg::REG_WIDTH:   wd_ff    <= csr_data[ppp_pkg::DIM_W-1:0];
            ppp_pkg::REG_HEIGHT:  ht_ff    <= csr_data[ppp_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign req_busy = 1'b0;
   assign accept   = req_start && !req_busy;

   logic vx, vy, vw;
   logic signed [DW-1:0] cx, cy, cw;

   ppp_mac #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_mac_x (
      .clock, .reset, .in_valid(accept),
      .in_x(req_data.world_x), .in_y(req_data.world_y), .in_z(req_data.world_z),
      .m_x(row_x_ff[EW-1:0]), .m_y(row_y_ff[EW-1:0]), .m_z(row_z_ff[EW-1:0]),
      .m_t(row_t_ff[EW-1:0]), .out_valid(vx), .out_clip(cx));
   ppp_mac #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_mac_y (
      .clock, .reset, .in_valid(accept),
      .in_x(req_data.world_x), .in_y(req_data.world_y), .in_z(req_data.world_z),
      .m_x(row_x_ff[2*EW-1:EW]), .m_y(row_y_ff[2*EW-1:EW]), .m_z(row_z_ff[2*EW-1:EW]),
      .m_t(row_t_ff[2*EW-1:EW]), .out_valid(vy), .out_clip(cy));
   ppp_mac #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_mac_w (
      .clock, .reset, .in_valid(accept),
      .in_x(req_data.world_x), .in_y(req_data.world_y), .in_z(req_data.world_z),
      .m_x(wu_ff[EW-1:0]), .m_y(wu_ff[2*EW-1:EW]), .m_z(wl_ff[EW-1:0]),
      .m_t(wl_ff[2*EW-1:EW]), .out_valid(vw), .out_clip(cw));

   // Cell chain: dividend magnitudes shift in MSB first alongside the remainders.
   ppp_pkg::div_ctl_type ctl_c [NCELL+1];
   logic [DW-1:0] w_c  [NCELL+1];
   logic [DW:0]   rx_c [NCELL+1];
   logic [DW:0]   ry_c [NCELL+1];
   logic [QW-1:0] qx_c [NCELL+1];
   logic [QW-1:0] qy_c [NCELL+1];
   logic [NB-1:0] nx_c [NCELL+1];
   logic [NB-1:0] ny_c [NCELL+1];

   logic [DW-1:0] mx, my;
   always_comb begin
      mx = cx[DW-1] ? DW'(-cx) : DW'(cx);
      my = cy[DW-1] ? DW'(-cy) : DW'(cy);
      ctl_c[0].valid = vx && vy && vw;
      ctl_c[0].vis   = (cw > W_EPS);
      ctl_c[0].neg_x = cx[DW-1];
      ctl_c[0].neg_y = cy[DW-1];
      ctl_c[0].sat_x = 1'b0;
      ctl_c[0].sat_y = 1'b0;
      w_c[0]  = (cw > W_EPS) ? DW'(cw) : DW'(1);
      rx_c[0] = '0;
      ry_c[0] = '0;
      qx_c[0] = '0;
      qy_c[0] = '0;
      nx_c[0] = {mx[DW-2:0], FRAC_BITS'(0)};
      ny_c[0] = {my[DW-2:0], FRAC_BITS'(0)};
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ppp_pkg::div_ctl_type ctl_in;
      logic [QW-1:0] qx_o, qy_o;
      logic [NB-1:0] nx_ff, ny_ff;
      // Quotient bits that fall off the top mean the clamp is reached.
      always_comb begin
         ctl_in = ctl_c[i];
         ctl_in.sat_x = ctl_c[i].sat_x | qx_c[i][QW-1];
         ctl_in.sat_y = ctl_c[i].sat_y | qy_c[i][QW-1];
      end
      ppp_div_cell #(.QW(QW), .DW(DW)) u_cell (
         .clock, .reset,
         .in_ctl(ctl_in), .in_w(w_c[i]), .in_rx(rx_c[i]), .in_ry(ry_c[i]),
         .in_qx(qx_c[i]), .in_qy(qy_c[i]),
         .in_bx(nx_c[i][NB-1]), .in_by(ny_c[i][NB-1]),
         .out_ctl(ctl_c[i+1]), .out_w(w_c[i+1]), .out_rx(rx_c[i+1]), .out_ry(ry_c[i+1]),
         .out_qx(qx_o), .out_qy(qy_o));
      assign qx_c[i+1] = qx_o;
      assign qy_c[i+1] = qy_o;
      always_ff @(posedge clock) begin
         nx_ff <= {nx_c[i][NB-2:0], 1'b0};
         ny_ff <= {ny_c[i][NB-2:0], 1'b0};
      end
      assign nx_c[i+1] = nx_ff;
      assign ny_c[i+1] = ny_ff;
   end

   // Viewport: ndc clamped to 2^NL, then (ndc+1)*wd and (1-ndc)*ht, halved toward -inf.
   localparam int VW = NL + 3 + ppp_pkg::DIM_W;
   localparam logic signed [VW-1:0] ONE_Q = VW'(1) << FRAC_BITS;
   ppp_pkg::div_ctl_type ce;
   logic [DW-1:0] qxe, qye;
   logic signed [VW-1:0] ndx, ndy;
   logic signed [VW-1:0] ax_ff, ay_ff;
   logic v3_ff, vis3_ff;
   logic signed [VW-1:0] px_ff, py_ff;
   logic v4_ff, vis4_ff;
   logic signed [VW-1:0] hx, hy;
   localparam logic signed [VW-1:0] OMAX = VW'((64'd1 << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [VW-1:0] OMIN = -OMAX - VW'(1);

   always_comb begin
      ce  = ctl_c[NCELL];
      qxe = (ce.sat_x || qx_c[NCELL][QW-1]) ? NDC_LIM : DW'(qx_c[NCELL]);
      qye = (ce.sat_y || qy_c[NCELL][QW-1]) ? NDC_LIM : DW'(qy_c[NCELL]);
      ndx = ce.neg_x ? -VW'(qxe) : VW'(qxe);
      ndy = ce.neg_y ? -VW'(qye) : VW'(qye);
      hx  = px_ff >>> 1;
      hy  = py_ff >>> 1;
   end

   always_ff @(posedge clock) begin
      ax_ff <= ndx + ONE_Q;
      ay_ff <= ONE_Q - ndy;
      px_ff <= ax_ff * $signed({1'b0, wd_ff});
      py_ff <= ay_ff * $signed({1'b0, ht_ff});
      vis3_ff <= ce.vis;
      vis4_ff <= vis3_ff;
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= ce.valid;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      rsp_strobe = v4_ff;
      rsp_data.visible = vis4_ff;
      if (!vis4_ff) begin
         rsp_data.screen_x = '0;
         rsp_data.screen_y = '0;
      end else begin
         rsp_data.screen_x = (hx > OMAX) ? COORD_WIDTH'(OMAX) :
                             (hx < OMIN) ? COORD_WIDTH'(OMIN) : COORD_WIDTH'(hx);
         rsp_data.screen_y = (hy > OMAX) ? COORD_WIDTH'(OMAX) :
                             (hy < OMIN) ? COORD_WIDTH'(OMIN) : COORD_WIDTH'(hy);
      end
   end

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !req_busy)
      else $error("busy raised");
   a_invis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.visible |-> rsp_data.screen_x == 0 && rsp_data.screen_y == 0)
      else $error("hidden point with nonzero screen coords");
   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("strobe right after reset");
endmodule

[test/perspective_point_projection_core_tb.sv]
// Testbench for the perspective point projection core: random and directed points, checked by a predictor.
module perspective_point_projection_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q = 64'sd65536;
   localparam longint W_EPS = 64'sd6;

   class projection_scoreboard;
      logic [ppp_pkg::CSR_DATA_W-1:0] regs [8];
      ppp_pkg::rsp_type screen_q[$];
      int errors;
      int n_checked;
      int n_visible;

      function new();
         regs[ppp_pkg::REG_ROW_X]   = ppp_pkg::RST_ROW_X;
         regs[ppp_pkg::REG_ROW_Y]   = ppp_pkg::RST_ROW_Y;
         regs[ppp_pkg::REG_ROW_Z]   = ppp_pkg::RST_ROW_Z;
         regs[ppp_pkg::REG_ROW_T]   = ppp_pkg::RST_ROW_T;
         regs[ppp_pkg::REG_W_UPPER] = ppp_pkg::RST_W_UPPER;
         regs[ppp_pkg::REG_W_LOWER] = ppp_pkg::RST_W_LOWER;
         regs[ppp_pkg::REG_WIDTH]   = 64'(ppp_pkg::RST_WIDTH);
         regs[ppp_pkg::REG_HEIGHT]  = 64'(ppp_pkg::RST_HEIGHT);
         errors = 0;
         n_checked = 0;
         n_visible = 0;
      endfunction

      function void set_reg(ppp_pkg::csr_idx_type idx, logic [ppp_pkg::CSR_DATA_W-1:0] val);
         if (idx == ppp_pkg::REG_WIDTH || idx == ppp_pkg::REG_HEIGHT)
            val = val & 64'h7FFF;
         regs[idx] = val;
      endfunction

      function longint lo_ent(ppp_pkg::csr_idx_type idx);
         logic signed [31:0] e;
         e = regs[idx][31:0];
         return e;
      endfunction

      function longint hi_ent(ppp_pkg::csr_idx_type idx);
         logic signed [31:0] e;
         e = regs[idx][63:32];
         return e;
      endfunction

      // |a|,|b| <= 2^31 so the full product fits; >>> gives the floor
      function longint mul_fix(longint a, longint b);
         longint p;
         p = a * b;
         return p >>> 16;
      endfunction

      function longint div_fix(longint c, longint w);
         logic [127:0] num, q;
         logic [63:0] mc;
         longint r;
         mc = (c < 0) ? -c : c;
         num = {48'b0, mc, 16'b0};
         q = num / {64'b0, w};
         if (q > (128'd1 << 47))
            q = 128'd1 << 47;
         r = q[63:0];
         return (c < 0) ? -r : r;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648)
            return 32'sh80000000;
         return v[31:0];
      endfunction

      function ppp_pkg::rsp_type project_point(ppp_pkg::req_type p);
         longint x, y, z, cx, cy, cw, nx, ny, wd, ht;
         ppp_pkg::rsp_type r;
         x = p.world_x;
         y = p.world_y;
         z = p.world_z;
         wd = longint'(regs[ppp_pkg::REG_WIDTH][14:0]);
         ht = longint'(regs[ppp_pkg::REG_HEIGHT][14:0]);
         cx = mul_fix(x, lo_ent(ppp_pkg::REG_ROW_X)) + mul_fix(y, lo_ent(ppp_pkg::REG_ROW_Y))
            + mul_fix(z, lo_ent(ppp_pkg::REG_ROW_Z)) + lo_ent(ppp_pkg::REG_ROW_T);
         cy = mul_fix(x, hi_ent(ppp_pkg::REG_ROW_X)) + mul_fix(y, hi_ent(ppp_pkg::REG_ROW_Y))
            + mul_fix(z, hi_ent(ppp_pkg::REG_ROW_Z)) + hi_ent(ppp_pkg::REG_ROW_T);
         cw = mul_fix(x, lo_ent(ppp_pkg::REG_W_UPPER))
            + mul_fix(y, hi_ent(ppp_pkg::REG_W_UPPER))
            + mul_fix(z, lo_ent(ppp_pkg::REG_W_LOWER)) + hi_ent(ppp_pkg::REG_W_LOWER);
         r = '0;
         if (cw > W_EPS) begin
            nx = div_fix(cx, cw);
            ny = div_fix(cy, cw);
            r.screen_x = clamp32(((nx + ONE_Q) * wd) >>> 1);
            r.screen_y = clamp32(((ONE_Q - ny) * ht) >>> 1);
            r.visible = 1'b1;
         end
         return r;
      endfunction

      function void note_point(ppp_pkg::req_type p);
         screen_q.push_back(project_point(p));
      endfunction

      function void check_screen(ppp_pkg::rsp_type got);
         ppp_pkg::rsp_type exp;
         if (screen_q.size() == 0) begin
            $error("result with no point outstanding: %h", got);
            errors++;
            return;
         end
         exp = screen_q.pop_front();
         n_checked++;
         if (exp.visible)
            n_visible++;
         if (got.screen_x !== exp.screen_x) begin
            $error("screen_x: expected %0d, actual %0d", exp.screen_x, got.screen_x);
            errors++;
         end
         if (got.screen_y !== exp.screen_y) begin
            $error("screen_y: expected %0d, actual %0d", exp.screen_y, got.screen_y);
            errors++;
         end
         if (got.visible !== exp.visible) begin
            $error("visible: expected %0b, actual %0b", exp.visible, got.visible);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_start;
   logic req_busy;
   ppp_pkg::req_type req_data;
   logic rsp_strobe;
   ppp_pkg::rsp_type rsp_data;
   logic csr_write;
   logic [ppp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ppp_pkg::CSR_DATA_W-1:0] csr_data;

   projection_scoreboard sb = new();
   bit idle_on;
   int n_sent;

   perspective_point_projection_core dut (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_screen(rsp_data);
   end

   // all tasks start and end just after a falling edge
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while (idle_on && $urandom_range(0, 99) < 15) begin
         req_start = 1'b0;
         req_data = {$urandom, $urandom, $urandom};
         @(negedge clock);
      end
      req_start = 1'b1;
      req_data.world_x = x;
      req_data.world_y = y;
      req_data.world_z = z;
      while (req_busy)
         @(negedge clock);
      sb.note_point(req_data);
      n_sent++;
      @(negedge clock);
      req_start = 1'b0;
   endtask

   task automatic drain();
      while (sb.screen_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(ppp_pkg::csr_idx_type idx, logic [ppp_pkg::CSR_DATA_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hFFFFFFFF;
            endcase
         end
         4, 5, 6: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
         default: return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
      endcase
   endfunction

   function automatic logic [31:0] pick_entry();
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         3: return 32'h0;
         default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      endcase
   endfunction

   task automatic random_matrix();
      for (int i = 0; i < 6; i++)
         write_reg(ppp_pkg::csr_idx_type'(i), {pick_entry(), pick_entry()});
      write_reg(ppp_pkg::REG_WIDTH,
                $urandom_range(0, 3) == 0 ? 64'($urandom) : 64'($urandom_range(0, 4096)));
      write_reg(ppp_pkg::REG_HEIGHT,
                $urandom_range(0, 3) == 0 ? 64'($urandom) : 64'($urandom_range(0, 4096)));
   endtask

   task automatic random_points(int n);
      for (int i = 0; i < n; i++)
         send_point(pick_coord(), pick_coord(), pick_coord());
   endtask

   initial begin
      reset = 1'b1;
      req_start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      n_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset matrix: identity-like, w = 1.0
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h0);
      send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
      drain();

      // w = z: threshold edge, behind the eye, division saturation
      write_reg(ppp_pkg::REG_W_LOWER, {32'h0, 32'h00010000});
      write_reg(ppp_pkg::REG_ROW_T, {32'h00008000, 32'hFFFF8000});
      send_point(32'h00010000, 32'h00010000, 32'd6);
      send_point(32'h00010000, 32'h00010000, 32'd7);
      send_point(32'h00010000, 32'h00010000, 32'd0);
      send_point(32'h00010000, 32'h00010000, 32'hFFFFFFFF);
      send_point(32'h80000000, 32'h7FFFFFFF, 32'd7);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      drain();

      // extreme matrix and oversized viewport
      for (int i = 0; i < 6; i++)
         write_reg(ppp_pkg::csr_idx_type'(i), 64'h7FFFFFFF_80000000);
      write_reg(ppp_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(ppp_pkg::REG_HEIGHT, 64'd16384);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(32'h80000000, 32'h80000000, 32'h80000000);
      send_point(32'h00010000, 32'h0, 32'h0);
      send_point(32'hFFFF0000, 32'h0, 32'h0);
      drain();
      write_reg(ppp_pkg::REG_WIDTH, 64'd0);
      write_reg(ppp_pkg::REG_HEIGHT, 64'd0);
      send_point(32'hFFFF0000, 32'h0, 32'h0);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      drain();

      // w lower entries set to 1.0 (z and constant), random points, then more under random matrices
      write_reg(ppp_pkg::REG_W_LOWER, {32'h00010000, 32'h00010000});
      write_reg(ppp_pkg::REG_WIDTH, 64'd1920);
      write_reg(ppp_pkg::REG_HEIGHT, 64'd1080);
      random_points(250);
      drain();
      idle_on = 1'b0;
      random_points(250);
      drain();
      idle_on = 1'b1;
      for (int ph = 0; ph < 5; ph++) begin
         random_matrix();
         random_points(210);
         drain();
      end

      repeat (80) @(negedge clock);
      $display("Covered %0d points (%0d visible) over several matrix and viewport settings,",
               sb.n_checked, sb.n_visible);
      $display("including threshold, behind-eye, saturation and extreme-register cases.");
      if (sb.errors == 0 && sb.screen_q.size() == 0 && sb.n_checked == n_sent)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
